// File: hw/rtl/efd_pkg.sv
package efd_pkg;

	// Escape prefix and the codes that may follow it
	localparam logic [7:0] ESC_PREFIX  = 8'h55;
	localparam logic [7:0] ESC_START   = 8'h01;
	localparam logic [7:0] ESC_LITERAL = 8'h02;
	localparam logic [7:0] ESC_END     = 8'h03;

	// Result kinds
	localparam logic [1:0] KIND_DATA     = 2'd0;
	localparam logic [1:0] KIND_ACCEPT   = 2'd1;
	localparam logic [1:0] KIND_CSUM_ERR = 2'd2;
	localparam logic [1:0] KIND_OVERFLOW = 2'd3;

	localparam logic [15:0] MAX_LENGTH_RESET = 16'd256;

	// One result transaction
	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  data_byte;
		logic [15:0] frame_length;
	} efd_result_t;

	// Decoder step outcome handed to the output register
	typedef struct packed {
		logic        has_result;
		efd_result_t result;
	} efd_step_t;

endpackage

// File: hw/rtl/efd_in_stage.sv
module efd_in_stage (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	input  logic       advance,
	output logic       valid_s1,
	output logic [7:0] byte_s1
);

	logic load;

	// hold while the registered byte cannot move on
	assign in_stall = valid_s1 && !advance;
	assign load     = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// payload, no reset
	always_ff @(posedge clk) begin
		if (load) begin
			byte_s1 <= rx_byte;
		end
	end

endmodule

// File: hw/rtl/efd_decode.sv
module efd_decode (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_write,
	input  logic [15:0]      cfg_data,
	input  logic             advance,
	input  logic [7:0]       byte_s1,
	output efd_pkg::efd_step_t step
);
	import efd_pkg::*;

	logic [15:0] max_length_q;
	logic        esc_q;
	logic [15:0] count_q;
	logic [7:0]  sum_q;
	logic [7:0]  last_q;

	logic        esc_d;
	logic [15:0] count_d;
	logic [7:0]  sum_d;
	logic [7:0]  last_d;
	logic        store;
	logic [7:0]  store_byte;
	logic        clear;

	// frame length limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_length_q <= MAX_LENGTH_RESET;
		end else if (cfg_write) begin
			max_length_q <= cfg_data;
		end
	end

	// decode one byte against the escape state
	always_comb begin
		step       = '0;
		esc_d      = esc_q;
		store      = 1'b0;
		store_byte = byte_s1;
		clear      = 1'b0;
		if (esc_q) begin
			esc_d = 1'b0;
			unique case (byte_s1)
				ESC_START: begin
					clear = 1'b1;
				end
				ESC_LITERAL: begin
					store      = 1'b1;
					store_byte = ESC_PREFIX;
				end
				ESC_END: begin
					clear           = 1'b1;
					step.has_result = 1'b1;
					if (count_q != 16'd0 && sum_q == last_q) begin
						step.result.kind         = KIND_ACCEPT;
						step.result.frame_length = count_q;
					end else begin
						step.result.kind = KIND_CSUM_ERR;
					end
				end
				default: begin
					store = 1'b1;
				end
			endcase
		end else if (count_q >= max_length_q) begin
			// overflow: drop the byte and restart the frame
			clear            = 1'b1;
			step.has_result  = 1'b1;
			step.result.kind = KIND_OVERFLOW;
		end else if (byte_s1 == ESC_PREFIX) begin
			esc_d = 1'b1;
		end else begin
			store = 1'b1;
		end

		if (store) begin
			step.has_result       = 1'b1;
			step.result.kind      = KIND_DATA;
			step.result.data_byte = store_byte;
		end
	end

	// frame counters; the sum trails by one stored byte
	always_comb begin
		count_d = count_q;
		sum_d   = sum_q;
		last_d  = last_q;
		if (clear) begin
			count_d = '0;
			sum_d   = '0;
			last_d  = '0;
		end else if (store) begin
			if (count_q != 16'd0) begin
				sum_d = sum_q + last_q;
			end
			last_d  = store_byte;
			count_d = count_q + 16'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q   <= 1'b0;
			count_q <= '0;
			sum_q   <= '0;
			last_q  <= '0;
		end else if (advance) begin
			esc_q   <= esc_d;
			count_q <= count_d;
			sum_q   <= sum_d;
			last_q  <= last_d;
		end
	end

endmodule

// File: hw/rtl/efd_out_reg.sv
module efd_out_reg (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               advance,
	input  efd_pkg::efd_step_t step,
	output logic               out_free,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [1:0]         kind,
	output logic [7:0]         data_byte,
	output logic [15:0]        frame_length
);
	import efd_pkg::*;

	logic        valid_q;
	efd_result_t result_q;

	// room for a new result when empty or the held one is taken now
	assign out_free = !valid_q || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= step.has_result;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step.has_result) begin
			result_q <= step.result;
		end
	end

	assign out_valid    = valid_q;
	assign kind         = result_q.kind;
	assign data_byte    = result_q.data_byte;
	assign frame_length = result_q.frame_length;

endmodule

// File: hw/rtl/escaped_frame_decoder.sv
// Byte-stuffed frame decoder with 8-bit additive checksum.
// An accepted byte is registered in the input stage, then decoded into the output register.
// Throughput: one byte per cycle; only a stalled output register holds the input.
// Reset (arst_n, async, active low): escape, count and sums cleared, max_length 256.
// Bytes that give no result (prefix, start marker) still pass the output stage once.
module escaped_frame_decoder (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_write,
	input  logic [15:0] cfg_data,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  kind,
	output logic [7:0]  data_byte,
	output logic [15:0] frame_length
);
	import efd_pkg::*;

	logic      valid_s1;
	logic [7:0] byte_s1;
	logic      out_free;
	logic      advance;
	efd_step_t step;

	// registered byte moves into the decoder when the result slot is free
	assign advance = valid_s1 && out_free;

	efd_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.rx_byte  (rx_byte),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1)
	);

	efd_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_data  (cfg_data),
		.advance   (advance),
		.byte_s1   (byte_s1),
		.step      (step)
	);

	efd_out_reg u_out_reg (
		.clk          (clk),
		.arst_n       (arst_n),
		.advance      (advance),
		.step         (step),
		.out_free     (out_free),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.data_byte    (data_byte),
		.frame_length (frame_length)
	);

endmodule

// File: tb/escaped_frame_decoder_test.sv
module escaped_frame_decoder_test;
	timeunit 1ns;
	timeprecision 1ps;

	import efd_pkg::*;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int DRAIN_CYCLES = 8;

	typedef logic [7:0] byte_seq_t[$];
	typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_e;

	// Decoder state mirror and queue of results still owed by the block
	class frame_scoreboard;
		logic [15:0] max_len;
		bit          esc_pending;
		logic [15:0] stored_cnt;
		logic [7:0]  sum_prev;
		logic [7:0]  last_byte;
		efd_result_t owed_q[$];
		int n_bytes, n_results, n_fail, n_accept, n_csum_err, n_overflow;

		function new();
			max_len = MAX_LENGTH_RESET;
			esc_pending = 1'b0;
			clear_frame();
			n_bytes = 0;
			n_results = 0;
			n_fail = 0;
			n_accept = 0;
			n_csum_err = 0;
			n_overflow = 0;
		endfunction

		function void clear_frame();
			stored_cnt = '0;
			sum_prev = '0;
			last_byte = '0;
		endfunction

		function void owe(logic [1:0] k, logic [7:0] d, logic [15:0] l);
			efd_result_t r;
			r.kind = k;
			r.data_byte = d;
			r.frame_length = l;
			owed_q.push_back(r);
		endfunction

		// Data byte goes into the frame; previous last byte joins the running sum
		function void store(logic [7:0] b);
			if (stored_cnt != 0)
				sum_prev = sum_prev + last_byte;
			last_byte = b;
			stored_cnt = stored_cnt + 16'd1;
			owe(KIND_DATA, b, 16'd0);
		endfunction

		// One accepted input transaction
		function void note_byte(logic [7:0] b);
			n_bytes++;
			if (esc_pending) begin
				// byte after a prefix is never overflow-checked
				esc_pending = 1'b0;
				case (b)
					ESC_START: clear_frame();
					ESC_LITERAL: store(ESC_PREFIX);
					ESC_END: begin
						if (stored_cnt != 0 && sum_prev == last_byte)
							owe(KIND_ACCEPT, 8'd0, stored_cnt);
						else
							owe(KIND_CSUM_ERR, 8'd0, 16'd0);
						clear_frame();
					end
					default: store(b);
				endcase
			end else if (stored_cnt >= max_len) begin
				clear_frame();
				owe(KIND_OVERFLOW, 8'd0, 16'd0);
			end else if (b == ESC_PREFIX) begin
				esc_pending = 1'b1;
			end else begin
				store(b);
			end
		endfunction

		// One accepted output transaction against the oldest owed result
		function void check_result(logic [1:0] k, logic [7:0] d, logic [15:0] l);
			efd_result_t want;
			n_results++;
			if (owed_q.size() == 0) begin
				n_fail++;
				$display("%0t: unexpected result, kind %0d data %h length %0d",
					$time, k, d, l);
				return;
			end
			want = owed_q.pop_front();
			case (want.kind)
				KIND_ACCEPT: n_accept++;
				KIND_CSUM_ERR: n_csum_err++;
				KIND_OVERFLOW: n_overflow++;
				default: ;
			endcase
			if (k !== want.kind) begin
				n_fail++;
				$display("%0t: kind expected %0d actual %0d", $time, want.kind, k);
			end
			if (d !== want.data_byte) begin
				n_fail++;
				$display("%0t: data_byte expected %h actual %h", $time, want.data_byte, d);
			end
			if (l !== want.frame_length) begin
				n_fail++;
				$display("%0t: frame_length expected %0d actual %0d",
					$time, want.frame_length, l);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        cfg_write;
	logic [15:0] cfg_data;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  rx_byte;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic [15:0] frame_length;

	frame_scoreboard sb = new();

	int cycle_cnt = 0;
	int bytes_sent = 0;
	int burst_left = 0;
	int gap_max = 0;
	int n_settings = 0;

	escaped_frame_decoder dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_write    (cfg_write),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.rx_byte      (rx_byte),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.kind         (kind),
		.data_byte    (data_byte),
		.frame_length (frame_length)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Monitors on both channels, plus the run limit
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (arst_n && in_valid && !in_stall)
			sb.note_byte(rx_byte);
		if (arst_n && out_valid && !out_stall)
			sb.check_result(kind, data_byte, frame_length);
		if (cycle_cnt >= CYCLE_LIMIT) begin
			$display("run limit of %0d cycles reached, %0d results still owed",
				CYCLE_LIMIT, sb.owed_q.size());
			$display("escaped_frame_decoder: mismatch");
			$finish;
		end
	end

	// Receiver stall: regimes of no stall, random stall and a repeating pattern
	stall_mode_e stall_mode = STALL_NONE;
	int          stall_tick = 0;
	int          stall_pct = 0;
	logic [7:0]  stall_pat = '0;

	always @(negedge clk) begin
		if (stall_tick % 48 == 0) begin
			stall_mode = stall_mode_e'($urandom_range(0, 2));
			stall_pct = $urandom_range(10, 75);
			stall_pat = 8'($urandom) & 8'hFE;
		end
		case (stall_mode)
			STALL_NONE: out_stall <= 1'b0;
			STALL_RANDOM: out_stall <= ($urandom_range(0, 99) < stall_pct);
			default: out_stall <= stall_pat[stall_tick[2:0]];
		endcase
		stall_tick++;
	end

	// One input transaction; bursts of random length with random gaps between
	task automatic send_byte(input logic [7:0] b);
		int idle;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 32);
			idle = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (idle > 0) begin
				@(negedge clk);
				in_valid <= 1'b0;
				rx_byte <= 8'($urandom);
				repeat (idle - 1) @(negedge clk);
			end
		end
		@(negedge clk);
		in_valid <= 1'b1;
		rx_byte <= b;
		do @(posedge clk); while (in_stall);
		burst_left--;
		bytes_sent++;
	endtask

	task automatic send_seq(input byte_seq_t s);
		foreach (s[i])
			send_byte(s[i]);
	endtask

	// Stored byte on the line: plain, literal escape, or prefix plus itself
	task automatic send_stored(input logic [7:0] b);
		if (b == ESC_PREFIX) begin
			send_byte(ESC_PREFIX);
			send_byte($urandom_range(0, 1) ? ESC_LITERAL : ESC_PREFIX);
		end else if (b > ESC_END && $urandom_range(0, 9) == 0) begin
			send_byte(ESC_PREFIX);
			send_byte(b);
		end else begin
			send_byte(b);
		end
	endtask

	// Start marker, n data bytes, checksum byte, optional end marker
	task automatic send_frame(input int n, input bit good, input bit closed);
		logic [7:0] sum;
		logic [7:0] v;
		sum = '0;
		send_byte(ESC_PREFIX);
		send_byte(ESC_START);
		for (int i = 0; i < n; i++) begin
			v = 8'($urandom);
			if ($urandom_range(0, 7) == 0)
				v = ESC_PREFIX;
			send_stored(v);
			sum = sum + v;
		end
		v = good ? sum : sum ^ (8'd1 << $urandom_range(0, 7));
		send_stored(v);
		if (closed) begin
			send_byte(ESC_PREFIX);
			send_byte(ESC_END);
		end
	endtask

	// Let every owed result come out, then give the pipe time to empty
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		burst_left = 0;
		while (sb.owed_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_max_length(input logic [15:0] v);
		wait_idle();
		@(negedge clk);
		cfg_write <= 1'b1;
		cfg_data <= v;
		@(negedge clk);
		cfg_write <= 1'b0;
		sb.max_len = v;
		n_settings++;
	endtask

	// Mostly well-formed frames, some cut short or with bad checksums, some noise
	task automatic run_phase(input logic [15:0] v, input int n_target, input int gmax);
		int start;
		int pick;
		int n;
		int lim;
		set_max_length(v);
		gap_max = gmax;
		start = bytes_sent;
		lim = (v >= 2) ? ((v - 2 < 24) ? v - 2 : 24) : 0;
		while (bytes_sent - start < n_target) begin
			pick = $urandom_range(0, 99);
			if (pick < 80) begin
				if (v <= 300 && $urandom_range(0, 9) == 0)
					n = int'(v) - 2 + int'($urandom_range(0, 2));
				else
					n = $urandom_range(0, lim);
				if (n < 0)
					n = 0;
				send_frame(n, $urandom_range(0, 4) != 0, $urandom_range(0, 9) != 0);
			end else if (pick < 90) begin
				repeat ($urandom_range(1, 6)) send_byte(8'($urandom));
			end else begin
				repeat ($urandom_range(1, 6))
					send_byte($urandom_range(0, 1) ? ESC_PREFIX : 8'($urandom_range(0, 4)));
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_write = 1'b0;
		cfg_data = '0;
		in_valid = 1'b0;
		rx_byte = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed at the reset length: data before start, bad and empty ends,
		// literal and other escapes, one-byte and good frames
		gap_max = 2;
		send_seq('{8'h00, 8'hFF, ESC_PREFIX, ESC_END});
		send_seq('{ESC_PREFIX, ESC_END});
		send_seq('{ESC_PREFIX, ESC_START, ESC_PREFIX, ESC_LITERAL, ESC_PREFIX, 8'hAA,
			8'hFF, ESC_PREFIX, ESC_END});
		send_seq('{ESC_PREFIX, ESC_START, 8'h00, ESC_PREFIX, ESC_END});
		send_seq('{ESC_PREFIX, ESC_START, 8'h12, 8'h34, ESC_PREFIX, ESC_END});
		send_seq('{ESC_PREFIX, ESC_PREFIX});

		// Short length: overflow on data, on a prefix, and no check after a prefix
		set_max_length(16'd4);
		send_seq('{ESC_PREFIX, ESC_START, 8'h10, 8'h20, 8'h30, 8'h40, 8'h50});
		send_seq('{8'h01, 8'h02, 8'h03, 8'h04, ESC_PREFIX});
		send_seq('{8'h81, 8'h42, 8'h24, ESC_PREFIX, 8'h77, ESC_PREFIX, ESC_END});

		// Zero length: every byte overflows
		set_max_length(16'd0);
		send_seq('{8'h00, ESC_PREFIX, ESC_END, 8'hFF});

		// Length one
		set_max_length(16'd1);
		send_seq('{ESC_PREFIX, ESC_START, ESC_PREFIX, 8'h00, ESC_PREFIX, 8'h7E});

		// Random phases across the length range
		run_phase(16'd65535, 100, 6);
		run_phase(MAX_LENGTH_RESET, 110, 0);
		run_phase(16'd1, 40, 3);
		run_phase(16'($urandom_range(2, 40)), 100, 4);
		run_phase(16'($urandom_range(3, 12)), 100, 2);
		run_phase(16'd16, 100, 8);

		wait_idle();
		$display("%0d bytes sent over %0d length settings; %0d results checked",
			bytes_sent, n_settings, sb.n_results);
		$display("frames accepted %0d, checksum errors %0d, overflows %0d",
			sb.n_accept, sb.n_csum_err, sb.n_overflow);
		if (sb.n_fail == 0)
			$display("escaped_frame_decoder: match");
		else
			$display("escaped_frame_decoder: mismatch");
		$finish;
	end

endmodule
